/* rtl/core/sha1md_pkg.sv */
// sha1md_pkg: shared types and constants for the sha-1 message digest core
// holds the initial hash words, the round constants and the padding marker
// no dependencies
`timescale 1ns / 1ps

package sha1md_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] word_t;
  typedef logic [2:0]  widx_t;

  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned ROUNDS       = 80;

  // initial chaining value
  localparam word_t INIT_WORDS [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // round constants, one per group of twenty rounds
  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  // first padding byte
  localparam byte_t PAD_MARK = 8'h80;

  function automatic word_t rotl(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

/* rtl/core/sha1md_if.sv */
// sha1md_if: valid/ready channels of the sha-1 core, message bytes in and digest words out
// depends on sha1md_pkg
`timescale 1ns / 1ps

interface sha1md_in_if;
  import sha1md_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  byte_present;
  logic  end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha1md_out_if;
  import sha1md_pkg::*;

  logic  valid;
  logic  ready;
  word_t digest_word;
  widx_t word_index;
  logic  last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

/* rtl/core/sha1_message_digest_core.sv */
// sha1_message_digest_core: sha-1 over a byte stream, five digest words per message
// depends on sha1md_pkg and the channel interfaces in sha1md_if
`timescale 1ns / 1ps

// usage
//   msg channel: one item per cycle while ready is high; an item carries an
//   optional message byte and an end-of-message flag. an item with neither
//   changes nothing.
//   digest channel: after an end-of-message item the core emits five items,
//   word_index 0..4, most significant word first, last_word on index 4.
// block processing
//   the 64th byte of a block starts the round unit, which does one round per
//   cycle and then adds into the chaining value, with msg.ready low; no byte
//   is taken until the single round unit is done with the block.
//   finalizing writes padding one byte per cycle up to the block end, then
//   compresses that block; when the length field does not fit, a second
//   block of padding is written and compressed. then the five digest items
//   follow, one per cycle when the receiver is ready.
// reset and stall
//   synchronous reset loads the initial hash words and clears the byte
//   counts; the core is ready in the cycle after reset. while the receiver
//   stalls, the current digest item holds and no message item is taken.
module sha1_message_digest_core (
  input  logic                clk,
  input  logic                rst,
  sha1md_in_if.sink           msg,
  sha1md_out_if.source        digest
);
  import sha1md_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [5:0] LAST_POS   = 6'd63;

  logic [2:0]   state;
  logic [5:0]   fill;          // bytes pending in the block
  logic [60:0]  msg_len;       // message length in bytes
  logic [511:0] blk;           // block shift line, word 0 at the top
  logic [6:0]   round;
  word_t        a, b, c, d, e;
  word_t        cv [DIGEST_WORDS];
  widx_t        out_idx;
  logic         padding;       // finalizing the current message
  logic         marker_sent;   // 0x80 already written
  logic         len_ok;        // length field goes in this block
  logic         last_blk;      // block holding the length field is full

  logic         take;
  logic         write_byte;
  byte_t        new_byte;
  byte_t        pad_byte;
  logic [63:0]  bit_len;
  word_t        w_cur, w_new;
  word_t        f, k, t_sum;

  // handshake
  assign msg.ready          = (state == S_IDLE);
  assign take               = msg.valid && msg.ready;
  assign digest.valid       = (state == S_OUT);
  assign digest.digest_word = cv[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == widx_t'(DIGEST_WORDS - 1));

  // padding byte: marker, zeros, then the bit length big-endian
  assign bit_len = {msg_len, 3'b000};
  always_comb begin
    if (!marker_sent) begin
      pad_byte = PAD_MARK;
    end else if (len_ok && fill >= LEN_POS) begin
      pad_byte = 8'(bit_len >> {~fill[2:0], 3'b000});
    end else begin
      pad_byte = '0;
    end
  end

  // byte entering the block line
  assign write_byte = (take && msg.byte_present) || (state == S_PAD);
  assign new_byte   = (state == S_PAD) ? pad_byte : msg.data_byte;

  // message schedule taps and the round function
  assign w_cur = blk[511:480];
  assign w_new = rotl(blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ w_cur, 1);

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t_sum = rotl(a, 5) + f + e + k + w_cur;

  // block line and working variables, no reset needed
  always_ff @(posedge clk) begin
    if (write_byte) begin
      blk <= {blk[503:0], new_byte};
    end else if (state == S_ROUND) begin
      blk <= {blk[479:0], w_new};
    end
    if (write_byte && fill == LAST_POS) begin
      a <= cv[0];
      b <= cv[1];
      c <= cv[2];
      d <= cv[3];
      e <= cv[4];
    end else if (state == S_ROUND) begin
      e <= d;
      d <= c;
      c <= rotl(b, 30);
      b <= a;
      a <= t_sum;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      msg_len     <= '0;
      round       <= '0;
      out_idx     <= '0;
      padding     <= 1'b0;
      marker_sent <= 1'b0;
      len_ok      <= 1'b0;
      last_blk    <= 1'b0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        cv[i] <= INIT_WORDS[i];
      end
    end else begin
      // byte bookkeeping shared by message and padding bytes
      if (write_byte) begin
        fill <= fill + 6'd1;
        if (fill == LAST_POS) begin
          round <= '0;
        end
      end

      case (state)
        S_IDLE: begin
          if (take) begin
            if (msg.byte_present) begin
              msg_len <= msg_len + 61'd1;
            end
            if (msg.end_of_message) begin
              padding     <= 1'b1;
              marker_sent <= 1'b0;
            end
            if (msg.byte_present && fill == LAST_POS) begin
              state <= S_ROUND;
            end else if (msg.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          marker_sent <= 1'b1;
          if (!marker_sent) begin
            len_ok <= (fill < LEN_POS);
          end
          if (fill == LAST_POS) begin
            last_blk <= marker_sent && len_ok;
            state    <= S_ROUND;
          end
        end
        S_ROUND: begin
          round <= round + 7'd1;
          if (round == LAST_ROUND) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          cv[0]  <= cv[0] + a;
          cv[1]  <= cv[1] + b;
          cv[2]  <= cv[2] + c;
          cv[3]  <= cv[3] + d;
          cv[4]  <= cv[4] + e;
          len_ok <= 1'b1;
          if (last_blk) begin
            out_idx <= '0;
            state   <= S_OUT;
          end else if (padding) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (digest.ready) begin
            out_idx <= out_idx + widx_t'(1);
            if (digest.last_word) begin
              state       <= S_IDLE;
              fill        <= '0;
              msg_len     <= '0;
              padding     <= 1'b0;
              marker_sent <= 1'b0;
              last_blk    <= 1'b0;
              for (int i = 0; i < DIGEST_WORDS; i++) begin
                cv[i] <= INIT_WORDS[i];
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> msg.ready)
    else $error("core not ready after reset");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg.ready && digest.valid))
    else $error("message item taken while digest pending");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round == LAST_ROUND) |=> state == S_ADD)
    else $error("round sequence did not end in the add step");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    digest.valid |-> out_idx < widx_t'(DIGEST_WORDS))
    else $error("digest word index out of range");

  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (digest.valid && digest.ready && digest.last_word) |=>
      (msg.ready && fill == 6'd0 && msg_len == 61'd0))
    else $error("core not cleared after final digest item");

endmodule

/* dv/tb_sha1_message_digest_core.sv */
// tb_sha1_message_digest_core: self-checking testbench for the sha-1 digest core
// drives message items, predicts the five digest words per message and checks them
// depends on sha1md_pkg, sha1md_if and sha1_message_digest_core
`timescale 1ns / 1ps

module tb_sha1_message_digest_core;
  import sha1md_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned ITEM_TARGET  = 150;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned DRAIN_CYCLES = 400;

  // well-known digests of the empty message and of "abc"
  localparam logic [159:0] EMPTY_DIGEST =
    160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
  localparam logic [159:0] ABC_DIGEST =
    160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

  // hash constants kept apart from the package so a typo there shows up
  localparam word_t SHA_IV [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam word_t ROUND_K [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  // message lengths around the padding and block edges
  localparam int unsigned EDGE_LENGTHS [6] = '{55, 56, 57, 63, 64, 65};

  typedef struct packed {
    word_t word;
    widx_t idx;
    logic  last;
  } digest_item_t;

  typedef struct {
    byte_t        data;
    logic         present;
    logic         eom;
    logic         typed;
    logic [159:0] digest;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha1md_in_if  msg_if ();
  sha1md_out_if digest_if ();

  sha1_message_digest_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .digest (digest_if)
  );

  // predictor state
  word_t       sha_chain [5];
  byte_t       sha_block [64];
  int unsigned block_fill;
  logic [60:0] byte_count;

  digest_item_t pending_words [$];
  stim_row_t    stim_table [$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  logic        steady         = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // one 80-round compression of sha_block into sha_chain
  function automatic void sha_compress();
    word_t w [80];
    word_t a, b, c, d, e, f, t;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {sha_block[4*i], sha_block[4*i+1], sha_block[4*i+2], sha_block[4*i+3]};
    for (i = 16; i < 80; i++) begin
      t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {t[30:0], t[31]};
    end
    a = sha_chain[0];
    b = sha_chain[1];
    c = sha_chain[2];
    d = sha_chain[3];
    e = sha_chain[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
      end else if (i < 40) begin
        f = b ^ c ^ d;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
      end else begin
        f = b ^ c ^ d;
      end
      t = {a[26:0], a[31:27]} + f + e + ROUND_K[i / 20] + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    sha_chain[0] += a;
    sha_chain[1] += b;
    sha_chain[2] += c;
    sha_chain[3] += d;
    sha_chain[4] += e;
  endfunction

  // pad, append the bit length, compress, then return to the initial value
  function automatic logic [159:0] sha_finish();
    logic [63:0]  bit_len;
    logic [159:0] result;
    int i;
    bit_len = {byte_count, 3'b000};
    sha_block[block_fill] = 8'h80;
    for (i = block_fill + 1; i < 64; i++)
      sha_block[i] = 8'h00;
    // no room for the length field: spill into an extra block
    if (block_fill + 1 > 56) begin
      sha_compress();
      for (i = 0; i < 64; i++)
        sha_block[i] = 8'h00;
    end
    for (i = 0; i < 8; i++)
      sha_block[63 - i] = bit_len[8*i +: 8];
    sha_compress();
    result = {sha_chain[0], sha_chain[1], sha_chain[2], sha_chain[3], sha_chain[4]};
    sha_chain  = SHA_IV;
    block_fill = 0;
    byte_count = '0;
    return result;
  endfunction

  // update the predictor with one accepted message item
  function automatic void take_msg_item(input byte_t d, input logic p, input logic eom,
                                        output logic done, output logic [159:0] dig);
    done = 1'b0;
    dig  = '0;
    if (p) begin
      sha_block[block_fill] = d;
      block_fill++;
      byte_count++;
      if (block_fill == 64) begin
        sha_compress();
        block_fill = 0;
      end
    end
    if (eom) begin
      dig  = sha_finish();
      done = 1'b1;
    end
  endfunction

  // drive one message item, with random idle cycles ahead of it
  task automatic send_item(input byte_t d, input logic p, input logic eom,
                           input logic typed, input logic [159:0] typed_digest);
    logic         done;
    logic [159:0] dig;
    int i;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      msg_if.valid          <= 1'b0;
      msg_if.data_byte      <= byte_t'($urandom_range(0, 255));
      msg_if.byte_present   <= 1'($urandom_range(0, 1));
      msg_if.end_of_message <= 1'($urandom_range(0, 1));
      @(posedge clk);
    end
    msg_if.valid          <= 1'b1;
    msg_if.data_byte      <= d;
    msg_if.byte_present   <= p;
    msg_if.end_of_message <= eom;
    @(posedge clk);
    while (msg_if.ready !== 1'b1)
      @(posedge clk);
    take_msg_item(d, p, eom, done, dig);
    if (done) begin
      if (typed)
        dig = typed_digest;
      for (i = 0; i < 5; i++)
        pending_words.push_back('{dig[159 - 32*i -: 32], widx_t'(i), (i == 4)});
    end
    if (p || eom)
      items_sent++;
  endtask

  // a whole message of random bytes, with stray empty items mixed in
  task automatic send_message(input int unsigned len, input logic end_on_byte);
    int unsigned k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
      send_item(byte_t'($urandom_range(0, 255)), 1'b1,
                end_on_byte && (k == len - 1), 1'b0, '0);
    end
    if (len == 0 || !end_on_byte)
      send_item(byte_t'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
  endtask

  // stimulus: reset, directed table, then random messages
  initial begin
    int unsigned msg_idx;
    int unsigned len;
    msg_if.valid          = 1'b0;
    msg_if.data_byte      = '0;
    msg_if.byte_present   = 1'b0;
    msg_if.end_of_message = 1'b0;
    sha_chain  = SHA_IV;
    block_fill = 0;
    byte_count = '0;
    foreach (sha_block[i])
      sha_block[i] = 8'h00;

    // empty item, empty message, "abc", byte extremes, ignored data, end without byte
    stim_table.push_back('{8'h5a, 1'b0, 1'b0, 1'b0, '0});
    stim_table.push_back('{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST});
    stim_table.push_back('{8'h61, 1'b1, 1'b0, 1'b0, '0});
    stim_table.push_back('{8'h62, 1'b1, 1'b0, 1'b0, '0});
    stim_table.push_back('{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST});
    stim_table.push_back('{8'h00, 1'b1, 1'b0, 1'b0, '0});
    stim_table.push_back('{8'hff, 1'b1, 1'b0, 1'b0, '0});
    stim_table.push_back('{8'ha5, 1'b0, 1'b0, 1'b0, '0});
    stim_table.push_back('{8'h3c, 1'b0, 1'b1, 1'b0, '0});
    stim_table.push_back('{8'hff, 1'b1, 1'b1, 1'b0, '0});
    stim_table.push_back('{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST});
    stim_table.push_back('{8'h00, 1'b1, 1'b1, 1'b0, '0});
    stim_table.push_back('{8'h80, 1'b1, 1'b1, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[r])
      send_item(stim_table[r].data, stim_table[r].present, stim_table[r].eom,
                stim_table[r].typed, stim_table[r].digest);

    // random messages, a few of them with no idling on either side
    msg_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      steady <= (msg_idx >= 4 && msg_idx < 9);
      if ($urandom_range(0, 2) == 0)
        len = EDGE_LENGTHS[$urandom_range(0, 5)];
      else
        len = $urandom_range(0, 20);
      send_message(len, 1'($urandom_range(0, 1)));
      msg_idx++;
    end
    steady       <= 1'b0;
    msg_if.valid <= 1'b0;

    // drain
    while (pending_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sha1_message_digest_core regression: pass");
    end else begin
      $display("sha1_message_digest_core regression: fail");
    end
    $finish;
  end

  // digest side: check each accepted item, then pick the next ready
  always @(posedge clk) begin
    digest_item_t want;
    if (!rst && digest_if.valid === 1'b1 && digest_if.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected digest item %h index %0d",
                                digest_if.digest_word, digest_if.word_index));
      end else begin
        want = pending_words.pop_front();
        if (digest_if.digest_word !== want.word)
          flag_mismatch($sformatf("digest_word index %0d: got %h want %h",
                                  want.idx, digest_if.digest_word, want.word));
        if (digest_if.word_index !== want.idx)
          flag_mismatch($sformatf("word_index: got %0d want %0d",
                                  digest_if.word_index, want.idx));
        if (digest_if.last_word !== want.last)
          flag_mismatch($sformatf("last_word index %0d: got %b want %b",
                                  want.idx, digest_if.last_word, want.last));
      end
    end
    digest_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sha1_message_digest_core regression: fail");
      $finish;
    end
  end

endmodule
